@@ sv/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants for the chebyshev stencil step
// Field widths, beat structs, register indexes and default fraction bits.
// ----------------------------------------------------------------------------
package cst_pkg;

  // fixed field widths
  localparam int VALUE_WIDTH   = 16;
  localparam int ACC_WIDTH     = 24;
  localparam int FRAC_BITS_DEF = 12;
  localparam int NUM_LANES     = 5;
  localparam int CFG_IDX_W     = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_MODE = 3'd0,
    CFG_COEF_A_RE = 3'd1,
    CFG_COEF_A_IM = 3'd2,
    CFG_COEF_B_RE = 3'd3,
    CFG_COEF_B_IM = 3'd4
  } cfg_idx_t;

  // step modes
  localparam logic MODE_FIRST = 1'b0;
  localparam logic MODE_RECUR = 1'b1;

  // input beat
  typedef struct packed {
    logic [2*VALUE_WIDTH-1:0] psi_center;
    logic [2*VALUE_WIDTH-1:0] psi_left;
    logic [2*VALUE_WIDTH-1:0] psi_right;
    logic [2*VALUE_WIDTH-1:0] psi_up;
    logic [2*VALUE_WIDTH-1:0] psi_down;
    logic [2*VALUE_WIDTH-1:0] hop_local;
    logic [2*VALUE_WIDTH-1:0] hop_left;
    logic [2*VALUE_WIDTH-1:0] hop_right;
    logic [2*VALUE_WIDTH-1:0] hop_up;
    logic [2*VALUE_WIDTH-1:0] hop_down;
    logic [2*VALUE_WIDTH-1:0] prev_output;
    logic [2*ACC_WIDTH-1:0]   prev_acc;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2*VALUE_WIDTH-1:0] new_output;
    logic [2*ACC_WIDTH-1:0]   new_acc;
  } out_item_t;

endpackage

@@ sv/cst_cmul.sv @@
// ----------------------------------------------------------------------------
// cst_cmul: registered complex multiply
// Four real products, each rounded half up to FRAC_BITS fraction bits,
// combined into real and imaginary parts and registered on load.
// ----------------------------------------------------------------------------
module cst_cmul #(
  parameter int FRAC_BITS = cst_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       load,
  input  logic signed [cst_pkg::VALUE_WIDTH-1:0]     a_re,
  input  logic signed [cst_pkg::VALUE_WIDTH-1:0]     a_im,
  input  logic signed [cst_pkg::VALUE_WIDTH-1:0]     b_re,
  input  logic signed [cst_pkg::VALUE_WIDTH-1:0]     b_im,
  output logic signed [2*cst_pkg::VALUE_WIDTH+1:0]   p_re,
  output logic signed [2*cst_pkg::VALUE_WIDTH+1:0]   p_im
);

  localparam int W  = cst_pkg::VALUE_WIDTH;
  localparam int PW = 2*W + 1;
  localparam int RW = 2*W + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

  logic signed [PW-1:0] prod_rr, prod_ii, prod_ri, prod_ir;
  logic signed [PW-1:0] rnd_rr, rnd_ii, rnd_ri, rnd_ir;
  logic signed [RW-1:0] p_re_nxt, p_im_nxt;
  logic signed [RW-1:0] p_re_r, p_im_r;

  // products with rounding constant, then floor shift
  always_comb begin
    prod_rr  = PW'(a_re) * PW'(b_re) + HALF;
    prod_ii  = PW'(a_im) * PW'(b_im) + HALF;
    prod_ri  = PW'(a_re) * PW'(b_im) + HALF;
    prod_ir  = PW'(a_im) * PW'(b_re) + HALF;
    rnd_rr   = prod_rr >>> FRAC_BITS;
    rnd_ii   = prod_ii >>> FRAC_BITS;
    rnd_ri   = prod_ri >>> FRAC_BITS;
    rnd_ir   = prod_ir >>> FRAC_BITS;
    p_re_nxt = RW'(rnd_rr) - RW'(rnd_ii);
    p_im_nxt = RW'(rnd_ri) + RW'(rnd_ir);
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      p_re_r <= p_re_nxt;
      p_im_r <= p_im_nxt;
    end
  end

  assign p_re = p_re_r;
  assign p_im = p_im_r;

endmodule

@@ sv/cst_merge.sv @@
// ----------------------------------------------------------------------------
// cst_merge: lane merge and output saturation
// Sums the lane products, applies the recurrence (2*sum - previous) when
// selected, saturates each part to the value width and registers it.
// ----------------------------------------------------------------------------
module cst_merge (
  input  logic                                     clk,
  input  logic                                     load,
  input  logic                                     step_mode,
  input  logic signed [2*cst_pkg::VALUE_WIDTH+1:0] lane_re [cst_pkg::NUM_LANES],
  input  logic signed [2*cst_pkg::VALUE_WIDTH+1:0] lane_im [cst_pkg::NUM_LANES],
  input  logic        [2*cst_pkg::VALUE_WIDTH-1:0] prev_output,
  output logic signed [cst_pkg::VALUE_WIDTH-1:0]   o_re,
  output logic signed [cst_pkg::VALUE_WIDTH-1:0]   o_im
);

  localparam int W  = cst_pkg::VALUE_WIDTH;
  localparam int RW = 2*W + 2;
  localparam int SW = RW + 3;
  localparam int TW = SW + 2;
  localparam logic signed [TW-1:0] VMAX = TW'((2**(W-1)) - 1);
  localparam logic signed [TW-1:0] VMIN = -VMAX - TW'(1);

  logic signed [SW-1:0] sum_re, sum_im;
  logic signed [TW-1:0] tot_re, tot_im;
  logic signed [W-1:0]  prev_re, prev_im;
  logic signed [W-1:0]  o_re_nxt, o_im_nxt;
  logic signed [W-1:0]  o_re_r, o_im_r;

  assign prev_re = $signed(prev_output[2*W-1:W]);
  assign prev_im = $signed(prev_output[W-1:0]);

  // adder over lanes
  always_comb begin
    sum_re = '0;
    sum_im = '0;
    for (int k = 0; k < cst_pkg::NUM_LANES; k++) begin
      sum_re = sum_re + SW'(lane_re[k]);
      sum_im = sum_im + SW'(lane_im[k]);
    end
  end

  // recurrence and saturation
  always_comb begin
    if (step_mode == cst_pkg::MODE_RECUR) begin
      tot_re = (TW'(sum_re) <<< 1) - TW'(prev_re);
      tot_im = (TW'(sum_im) <<< 1) - TW'(prev_im);
    end else begin
      tot_re = TW'(sum_re);
      tot_im = TW'(sum_im);
    end
    if (tot_re > VMAX)      o_re_nxt = W'(VMAX);
    else if (tot_re < VMIN) o_re_nxt = W'(VMIN);
    else                    o_re_nxt = W'(tot_re);
    if (tot_im > VMAX)      o_im_nxt = W'(VMAX);
    else if (tot_im < VMIN) o_im_nxt = W'(VMIN);
    else                    o_im_nxt = W'(tot_im);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_re_r <= o_re_nxt;
      o_im_r <= o_im_nxt;
    end
  end

  assign o_re = o_re_r;
  assign o_im = o_im_r;

endmodule

@@ sv/chebyshev_stencil_step.sv @@
// ----------------------------------------------------------------------------
// chebyshev_stencil_step: one lattice site of a Chebyshev evolution step
// Five complex multiply lanes form the stencil sum, a merge stage makes the
// new output, and a second multiply stage updates the accumulator.
//
//   channel | dir | handshake          | beat
//   in_     | in  | in_valid/in_stall  | cst_pkg::in_item_t
//   out_    | out | out_valid/out_stall| cst_pkg::out_item_t
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// four pipeline stages: lane multiply, merge, accumulator multiply, output
// one site per cycle while out_stall lets it; an accepted site passes v1_r, v2_r, v3_r, v4_r to out_valid
// each stage holds its beat while the stage after it is full and stalled
// rst_n (synchronous) clears stage valids and config registers; cfg_ready is always high
// ----------------------------------------------------------------------------
module chebyshev_stencil_step #(
  parameter int FRAC_BITS = cst_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cst_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output cst_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cst_pkg::VALUE_WIDTH-1:0]   cfg_data
);

  localparam int W  = cst_pkg::VALUE_WIDTH;
  localparam int A  = cst_pkg::ACC_WIDTH;
  localparam int RW = 2*W + 2;
  localparam int AW = ((A > RW) ? A : RW) + 2;
  localparam int NL = cst_pkg::NUM_LANES;
  localparam logic signed [AW-1:0] AMAX = AW'((2**(A-1)) - 1);
  localparam logic signed [AW-1:0] AMIN = -AMAX - AW'(1);

  // configuration registers
  logic                step_mode_r;
  logic signed [W-1:0] coef_a_re_r, coef_a_im_r, coef_b_re_r, coef_b_im_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_mode_r <= cst_pkg::MODE_FIRST;
      coef_a_re_r <= '0;
      coef_a_im_r <= '0;
      coef_b_re_r <= '0;
      coef_b_im_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cst_pkg::cfg_idx_t'(cfg_index))
        cst_pkg::CFG_STEP_MODE: step_mode_r <= cfg_data[0];
        cst_pkg::CFG_COEF_A_RE: coef_a_re_r <= $signed(cfg_data);
        cst_pkg::CFG_COEF_A_IM: coef_a_im_r <= $signed(cfg_data);
        cst_pkg::CFG_COEF_B_RE: coef_b_re_r <= $signed(cfg_data);
        cst_pkg::CFG_COEF_B_IM: coef_b_im_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // stage valids and flow control
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1, ld2, ld3, ld4;

  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign ld1      = in_valid && rdy1;
  assign ld2      = v1_r && rdy2;
  assign ld3      = v2_r && rdy3;
  assign ld4      = v3_r && rdy4;

  always_comb begin
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r     : v2_r;
    v3_nxt = rdy3 ? v2_r     : v3_r;
    v4_nxt = rdy4 ? v3_r     : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // lane operands: psi times hop per stencil point
  logic [2*W-1:0]        lane_psi [NL];
  logic [2*W-1:0]        lane_hop [NL];
  logic signed [RW-1:0]  lane_re  [NL];
  logic signed [RW-1:0]  lane_im  [NL];

  assign lane_psi[0] = in_data.psi_center;
  assign lane_psi[1] = in_data.psi_left;
  assign lane_psi[2] = in_data.psi_right;
  assign lane_psi[3] = in_data.psi_up;
  assign lane_psi[4] = in_data.psi_down;
  assign lane_hop[0] = in_data.hop_local;
  assign lane_hop[1] = in_data.hop_left;
  assign lane_hop[2] = in_data.hop_right;
  assign lane_hop[3] = in_data.hop_up;
  assign lane_hop[4] = in_data.hop_down;

  // stage 1: multiply lanes
  for (genvar k = 0; k < NL; k++) begin : g_lane
    cst_cmul #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .load (ld1),
      .a_re ($signed(lane_psi[k][2*W-1:W])),
      .a_im ($signed(lane_psi[k][W-1:0])),
      .b_re ($signed(lane_hop[k][2*W-1:W])),
      .b_im ($signed(lane_hop[k][W-1:0])),
      .p_re (lane_re[k]),
      .p_im (lane_im[k])
    );
  end

  // stage 1 side payload
  logic [2*W-1:0] center1_r, prev1_r;
  logic [2*A-1:0] acc1_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      center1_r <= in_data.psi_center;
      prev1_r   <= in_data.prev_output;
      acc1_r    <= in_data.prev_acc;
    end
  end

  // stage 2: merge lanes into the new output
  logic signed [W-1:0] o2_re, o2_im;
  logic [2*W-1:0]      center2_r;
  logic [2*A-1:0]      acc2_r;

  cst_merge u_merge (
    .clk         (clk),
    .load        (ld2),
    .step_mode   (step_mode_r),
    .lane_re     (lane_re),
    .lane_im     (lane_im),
    .prev_output (prev1_r),
    .o_re        (o2_re),
    .o_im        (o2_im)
  );

  always_ff @(posedge clk) begin
    if (ld2) begin
      center2_r <= center1_r;
      acc2_r    <= acc1_r;
    end
  end

  // stage 3: accumulator products
  logic signed [W-1:0]  xa_re, xa_im;
  logic signed [RW-1:0] ta_re, ta_im, tb_re, tb_im;
  logic signed [W-1:0]  o3_re_r, o3_im_r;
  logic [2*A-1:0]       acc3_r;

  // recurrence weights the output by A, first step weights the center by A
  assign xa_re = (step_mode_r == cst_pkg::MODE_RECUR) ? o2_re : $signed(center2_r[2*W-1:W]);
  assign xa_im = (step_mode_r == cst_pkg::MODE_RECUR) ? o2_im : $signed(center2_r[W-1:0]);

  cst_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (
    .clk  (clk),
    .load (ld3),
    .a_re (xa_re),
    .a_im (xa_im),
    .b_re (coef_a_re_r),
    .b_im (coef_a_im_r),
    .p_re (ta_re),
    .p_im (ta_im)
  );

  cst_cmul #(.FRAC_BITS(FRAC_BITS)) u_mul_b (
    .clk  (clk),
    .load (ld3),
    .a_re (o2_re),
    .a_im (o2_im),
    .b_re (coef_b_re_r),
    .b_im (coef_b_im_r),
    .p_re (tb_re),
    .p_im (tb_im)
  );

  always_ff @(posedge clk) begin
    if (ld3) begin
      o3_re_r <= o2_re;
      o3_im_r <= o2_im;
      acc3_r  <= acc2_r;
    end
  end

  // stage 4: accumulate, saturate, output register
  logic signed [AW-1:0] sum_re, sum_im;
  logic signed [AW-1:0] tbx_re, tbx_im;
  logic signed [A-1:0]  acc_re_nxt, acc_im_nxt;
  cst_pkg::out_item_t   out_r;

  always_comb begin
    if (step_mode_r == cst_pkg::MODE_RECUR) begin
      tbx_re = '0;
      tbx_im = '0;
    end else begin
      tbx_re = AW'(tb_re);
      tbx_im = AW'(tb_im);
    end
    sum_re = AW'($signed(acc3_r[2*A-1:A])) + AW'(ta_re) + tbx_re;
    sum_im = AW'($signed(acc3_r[A-1:0])) + AW'(ta_im) + tbx_im;
    if (sum_re > AMAX)      acc_re_nxt = A'(AMAX);
    else if (sum_re < AMIN) acc_re_nxt = A'(AMIN);
    else                    acc_re_nxt = A'(sum_re);
    if (sum_im > AMAX)      acc_im_nxt = A'(AMAX);
    else if (sum_im < AMIN) acc_im_nxt = A'(AMIN);
    else                    acc_im_nxt = A'(sum_im);
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      out_r.new_output <= {o3_re_r, o3_im_r};
      out_r.new_acc    <= {acc_re_nxt, acc_im_nxt};
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

  // empty output register means the whole pipe can move
  a_idle_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v4_r |-> !in_stall)
    else $error("input stalled while output register is empty");

  // an accepted beat lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted beat lost at stage 1");

  // a blocked stage keeps its beat
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> v1_r)
    else $error("stage 1 beat dropped while blocked");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> v2_r)
    else $error("stage 2 beat dropped while blocked");

endmodule

@@ tb/chebyshev_stencil_step_test.sv @@
// ----------------------------------------------------------------------------
// chebyshev_stencil_step_test: self-checking bench for the stencil step
// Streams lattice sites through the block under several register settings,
// predicts each result beat with a fixed-point model of the complex stencil
// and accumulator update, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module chebyshev_stencil_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     VALUE_WIDTH     = cst_pkg::VALUE_WIDTH;
  localparam int     ACC_WIDTH       = cst_pkg::ACC_WIDTH;
  localparam int     CFG_IDX_W       = cst_pkg::CFG_IDX_W;
  localparam int     NUM_LANES       = cst_pkg::NUM_LANES;
  localparam int     FRAC_BITS       = cst_pkg::FRAC_BITS_DEF;
  localparam longint HALF_LSB        = 64'sd1 <<< (FRAC_BITS - 1);
  localparam int     IDLE_PCT        = 17;
  localparam int     RAND_PHASES     = 8;
  localparam int     SITES_PER_PHASE = 216;
  localparam int     CALM_LO         = 900;
  localparam int     CALM_HI         = 1200;
  localparam int     HOLD_AT         = 500;
  localparam int     HOLD_CYCLES     = 200;
  localparam int     DRAIN_CYCLES    = 16;
  localparam longint TIMEOUT_NS      = 5_000_000;

  typedef struct packed {
    longint re;
    longint im;
  } cval_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  cst_pkg::in_item_t      in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  cst_pkg::out_item_t     out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [VALUE_WIDTH-1:0] cfg_data  = '0;

  // register copy used for prediction
  logic                          cur_mode = cst_pkg::MODE_FIRST;
  logic signed [VALUE_WIDTH-1:0] cur_a_re = '0;
  logic signed [VALUE_WIDTH-1:0] cur_a_im = '0;
  logic signed [VALUE_WIDTH-1:0] cur_b_re = '0;
  logic signed [VALUE_WIDTH-1:0] cur_b_im = '0;

  cst_pkg::in_item_t  site_pending [$];
  cst_pkg::out_item_t site_expect [$];

  int n_pushed     = 0;
  int n_accepted   = 0;
  int n_results    = 0;
  int n_errors     = 0;
  int n_settings   = 0;
  int n_cfg_writes = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  chebyshev_stencil_step uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // fixed-point complex helpers
  function automatic cval_t unpack_val(logic [2*VALUE_WIDTH-1:0] v);
    cval_t c;
    c.re = $signed(v[2*VALUE_WIDTH-1:VALUE_WIDTH]);
    c.im = $signed(v[VALUE_WIDTH-1:0]);
    return c;
  endfunction

  function automatic cval_t unpack_acc(logic [2*ACC_WIDTH-1:0] v);
    cval_t c;
    c.re = $signed(v[2*ACC_WIDTH-1:ACC_WIDTH]);
    c.im = $signed(v[ACC_WIDTH-1:0]);
    return c;
  endfunction

  // product rounded half up to the value's fraction bits
  function automatic longint mul_round(longint x, longint y);
    return (x * y + HALF_LSB) >>> FRAC_BITS;
  endfunction

  function automatic cval_t cmul(cval_t x, cval_t y);
    cval_t r;
    r.re = mul_round(x.re, y.re) - mul_round(x.im, y.im);
    r.im = mul_round(x.re, y.im) + mul_round(x.im, y.re);
    return r;
  endfunction

  function automatic longint clamp(longint x, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic logic [2*VALUE_WIDTH-1:0] pack_val(cval_t c);
    return {VALUE_WIDTH'(clamp(c.re, VALUE_WIDTH)), VALUE_WIDTH'(clamp(c.im, VALUE_WIDTH))};
  endfunction

  function automatic logic [2*ACC_WIDTH-1:0] pack_acc(cval_t c);
    return {ACC_WIDTH'(clamp(c.re, ACC_WIDTH)), ACC_WIDTH'(clamp(c.im, ACC_WIDTH))};
  endfunction

  // expected result beat for one site under the current registers
  function automatic cst_pkg::out_item_t predict_site(cst_pkg::in_item_t it);
    logic [2*VALUE_WIDTH-1:0] psi [NUM_LANES];
    logic [2*VALUE_WIDTH-1:0] hop [NUM_LANES];
    cval_t              sum;
    cval_t              t;
    cval_t              o;
    cval_t              prev;
    cval_t              a;
    cval_t              b;
    cval_t              acc;
    cst_pkg::out_item_t r;
    psi[0] = it.psi_center;
    psi[1] = it.psi_left;
    psi[2] = it.psi_right;
    psi[3] = it.psi_up;
    psi[4] = it.psi_down;
    hop[0] = it.hop_local;
    hop[1] = it.hop_left;
    hop[2] = it.hop_right;
    hop[3] = it.hop_up;
    hop[4] = it.hop_down;
    // five-point weighted sum
    sum = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      t = cmul(unpack_val(psi[k]), unpack_val(hop[k]));
      sum.re += t.re;
      sum.im += t.im;
    end
    // three-term recurrence
    if (cur_mode == cst_pkg::MODE_RECUR) begin
      prev   = unpack_val(it.prev_output);
      sum.re = 2 * sum.re - prev.re;
      sum.im = 2 * sum.im - prev.im;
    end
    r.new_output = pack_val(sum);
    o = unpack_val(r.new_output);
    // accumulator update from the saturated output
    a.re = cur_a_re;
    a.im = cur_a_im;
    acc  = unpack_acc(it.prev_acc);
    if (cur_mode == cst_pkg::MODE_RECUR) begin
      t = cmul(o, a);
      acc.re += t.re;
      acc.im += t.im;
    end else begin
      b.re = cur_b_re;
      b.im = cur_b_im;
      t = cmul(unpack_val(it.psi_center), a);
      acc.re += t.re;
      acc.im += t.im;
      t = cmul(o, b);
      acc.re += t.re;
      acc.im += t.im;
    end
    r.new_acc = pack_acc(acc);
    return r;
  endfunction

  // random value half: extremes, small magnitudes or any pattern
  function automatic logic [VALUE_WIDTH-1:0] rand_half();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    if (sel < 55) return VALUE_WIDTH'(int'($urandom_range(0, 2047)) - 1024);
    return VALUE_WIDTH'($urandom);
  endfunction

  function automatic logic [ACC_WIDTH-1:0] rand_acc_part();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      case ($urandom_range(0, 3))
        0: return 24'h7FFFFF;
        1: return 24'h800000;
        2: return 24'h7FF000 + ACC_WIDTH'($urandom_range(0, 4095));
        default: return 24'h800000 + ACC_WIDTH'($urandom_range(0, 4095));
      endcase
    end
    if (sel < 55) return ACC_WIDTH'(int'($urandom_range(0, 65535)) - 32768);
    return ACC_WIDTH'($urandom);
  endfunction

  function automatic cst_pkg::in_item_t rand_site();
    cst_pkg::in_item_t it;
    it.psi_center  = {rand_half(), rand_half()};
    it.psi_left    = {rand_half(), rand_half()};
    it.psi_right   = {rand_half(), rand_half()};
    it.psi_up      = {rand_half(), rand_half()};
    it.psi_down    = {rand_half(), rand_half()};
    it.hop_local   = {rand_half(), rand_half()};
    it.hop_left    = {rand_half(), rand_half()};
    it.hop_right   = {rand_half(), rand_half()};
    it.hop_up      = {rand_half(), rand_half()};
    it.hop_down    = {rand_half(), rand_half()};
    it.prev_output = {rand_half(), rand_half()};
    it.prev_acc    = {rand_acc_part(), rand_acc_part()};
    return it;
  endfunction

  // input driver: predicts on accept, then offers the next queued beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        site_expect.push_back(predict_site(in_data));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (site_pending.size() != 0 &&
            ((n_accepted >= CALM_LO && n_accepted < CALM_HI) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_data  <= site_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    cst_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (site_expect.size() == 0) begin
          $error("result beat with no expected result: %h", out_data);
          n_errors++;
        end else begin
          want = site_expect.pop_front();
          if (out_data.new_output !== want.new_output) begin
            $error("new_output: expected %h, got %h", want.new_output, out_data.new_output);
            n_errors++;
          end
          if (out_data.new_acc !== want.new_acc) begin
            $error("new_acc: expected %h, got %h", want.new_acc, out_data.new_acc);
            n_errors++;
          end
        end
        n_results++;
      end
      // one long hold-off so the pipeline backs up into the input
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && n_results >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0)
        out_stall <= 1'b1;
      else if (n_results >= CALM_LO && n_results < CALM_HI)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // one register write beat, mirrored into the register copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_WIDTH-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cst_pkg::CFG_STEP_MODE: cur_mode = data[0];
      cst_pkg::CFG_COEF_A_RE: cur_a_re = data;
      cst_pkg::CFG_COEF_A_IM: cur_a_im = data;
      cst_pkg::CFG_COEF_B_RE: cur_b_re = data;
      cst_pkg::CFG_COEF_B_IM: cur_b_im = data;
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  task automatic load_setting(input logic mode, input logic [VALUE_WIDTH-1:0] are, aim,
                              bre, bim);
    write_reg(cst_pkg::CFG_STEP_MODE, {15'($urandom), mode});
    write_reg(cst_pkg::CFG_COEF_A_RE, are);
    write_reg(cst_pkg::CFG_COEF_A_IM, aim);
    write_reg(cst_pkg::CFG_COEF_B_RE, bre);
    write_reg(cst_pkg::CFG_COEF_B_IM, bim);
    // unused indexes must be ignored
    if ($urandom_range(0, 1))
      write_reg(CFG_IDX_W'(cst_pkg::CFG_COEF_B_IM) + CFG_IDX_W'($urandom_range(1, 3)),
                VALUE_WIDTH'($urandom));
    n_settings++;
  endtask

  // site with every value half, weight half and accumulator part alike
  task automatic push_level(input logic [VALUE_WIDTH-1:0] psi, hop, prev,
                            input logic [ACC_WIDTH-1:0] accp);
    cst_pkg::in_item_t it;
    it.psi_center  = {psi, psi};
    it.psi_left    = {psi, psi};
    it.psi_right   = {psi, psi};
    it.psi_up      = {psi, psi};
    it.psi_down    = {psi, psi};
    it.hop_local   = {hop, hop};
    it.hop_left    = {hop, hop};
    it.hop_right   = {hop, hop};
    it.hop_up      = {hop, hop};
    it.hop_down    = {hop, hop};
    it.prev_output = {prev, prev};
    it.prev_acc    = {accp, accp};
    site_pending.push_back(it);
    n_pushed++;
  endtask

  task automatic push_directed();
    push_level(16'h0000, 16'h0000, 16'h0000, 24'h000000);
    push_level(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h7FFFFF);
    push_level(16'h8000, 16'h8000, 16'h8000, 24'h800000);
    push_level(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    // ties on the rounding point, positive and negative
    push_level(16'h0001, 16'h0800, 16'h8000, 24'h000000);
    push_level(16'hFFFF, 16'h0800, 16'h7FFF, 24'h7FFFFF);
    push_level(16'h7FFF, 16'h8000, 16'h8000, 24'h800000);
    // unit values
    push_level(16'h1000, 16'h1000, 16'h0000, 24'h000800);
  endtask

  // sender pause until every queued site has come back
  task automatic wait_idle();
    do @(posedge clk); while (n_accepted != n_pushed || site_expect.size() != 0);
  endtask

  // stimulus sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // registers at their reset values
    push_level(16'h0000, 16'h0000, 16'h0000, 24'h000000);
    push_level(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h7FFFFF);
    push_level(16'h8000, 16'h8000, 16'h8000, 24'h800000);
    wait_idle();

    // directed sites under extreme coefficients in both modes
    load_setting(cst_pkg::MODE_FIRST, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    push_directed();
    wait_idle();
    load_setting(cst_pkg::MODE_RECUR, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    push_directed();
    wait_idle();

    // random sites, one register setting per phase
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: load_setting(cst_pkg::MODE_FIRST, 16'h1000, 16'h0000, 16'h0000, 16'hF000);
        1: load_setting(cst_pkg::MODE_RECUR, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        2: load_setting(cst_pkg::MODE_FIRST, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        default: load_setting(logic'($urandom_range(0, 1)), rand_half(), rand_half(),
                              rand_half(), rand_half());
      endcase
      repeat (SITES_PER_PHASE) begin
        site_pending.push_back(rand_site());
        n_pushed++;
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d result beats from %0d sites under %0d register settings",
             n_results, n_accepted, n_settings);
    $display("%0d register writes, one %0d-cycle receiver hold-off", n_cfg_writes,
             HOLD_CYCLES);
    if (n_errors == 0 && site_expect.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
